### rtl/frs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types and constants of the Fresnel mirror reflection pipeline.
// ----------------------------------------------------------------------------
package frs_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_INSIDE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_OUTSIDE = 1'd1;

    localparam logic [15:0] INDEX_RESET = 16'd4096;
    localparam logic [15:0] INDEX_MIN   = 16'd1024;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [16:0] KR_ONE      = 17'h1_0000;
    localparam logic [23:0] WEIGHT_MAX  = 24'hFF_FFFF;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic signed [15:0] ray_dir_x;
        logic signed [15:0] ray_dir_y;
        logic signed [15:0] ray_dir_z;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] refl_x;
        logic signed [15:0] refl_y;
        logic signed [15:0] refl_z;
        logic        [16:0] reflectance;
        logic        [23:0] weight;
        logic               total_internal;
        logic               weight_saturated;
    } t_out_word;

    typedef struct packed {
        logic [62:0]      num;
        logic [31:0]      den;
        logic             tir;
        logic [30:0]      ci;
        logic [15:0]      a;
        logic [15:0]      b;
        logic [32:0]      c16;
        logic [2:0][15:0] refl;
        logic             sat;
    } t_front;

endpackage

`default_nettype wire

### rtl/fresnel_mirror_reflect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_mirror_reflect
// Mirror direction and dielectric Fresnel reflectance with cosine weight.
// ----------------------------------------------------------------------------
// throughput: one word per cycle; the whole pipeline advances together and
// holds while the output word waits
// the pipeline length is set by the four one-bit-per-stage units: sin^2 ratio divider
// (31 stages), cos_t square root (31), Fresnel ratio (17) and weight (24)
// reset: synchronous active-low, empties the pipeline, both indices to 1.0
module fresnel_mirror_reflect
    import frs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    localparam int FRONT_LAT = 7;
    localparam int Q_LAT     = 31;
    localparam int S_LAT     = 31;
    localparam int R_LAT     = 17;
    localparam int W_LAT     = 24;
    localparam int PIPE_LAT  = FRONT_LAT + Q_LAT + S_LAT + 2 + R_LAT + 3 + W_LAT + 1;

    typedef struct packed {
        logic [30:0]      ci;
        logic [15:0]      a;
        logic [15:0]      b;
        logic [32:0]      c16;
        logic [2:0][15:0] refl;
        logic             sat;
        logic             tir;
    } t_side_a;

    typedef struct packed {
        logic             zp;
        logic             zs;
        logic             tir;
        logic [32:0]      c16;
        logic [2:0][15:0] refl;
        logic             sat;
    } t_side_b;

    typedef struct packed {
        logic [16:0]      kr;
        logic             tir;
        logic             ovf;
        logic [2:0][15:0] refl;
        logic             sat;
    } t_side_c;

    logic                w_adv;
    logic [PIPE_LAT-1:0] r_valid;
    logic [15:0]         r_index_inside;
    logic [15:0]         r_index_outside;

    assign w_adv       = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_valid[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= '0;
            r_index_inside  <= INDEX_RESET;
            r_index_outside <= INDEX_RESET;
        end else begin
            if (w_adv) begin
                r_valid <= {r_valid[PIPE_LAT-2:0], i_in_valid};
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_INDEX_INSIDE:  r_index_inside  <= i_cfg_data;
                    REG_INDEX_OUTSIDE: r_index_outside <= i_cfg_data;
                endcase
            end
        end
    end

    // front arithmetic
    t_front w_front;

    frs_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_en            (w_adv),
        .i_word          (i_in_word),
        .i_index_inside  (r_index_inside),
        .i_index_outside (r_index_outside),
        .o_front         (w_front)
    );

    // sin^2(t) ratio and cos(t)
    logic [30:0] w_q;
    logic [30:0] w_ct;
    logic [61:0] w_sq_arg;
    t_side_a     w_side_a;
    t_side_a     w_side_a_d;

    frs_div #(
        .NW (63),
        .DW (32),
        .QW (Q_LAT)
    ) u_qdiv (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_front.num),
        .i_den (w_front.den),
        .o_quo (w_q)
    );

    assign w_sq_arg = 62'(Q30_ONE - w_q) << 30;

    frs_sqrt #(
        .RW (S_LAT)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_arg  (w_sq_arg),
        .o_root (w_ct)
    );

    always_comb begin
        w_side_a.ci   = w_front.ci;
        w_side_a.a    = w_front.a;
        w_side_a.b    = w_front.b;
        w_side_a.c16  = w_front.c16;
        w_side_a.refl = w_front.refl;
        w_side_a.sat  = w_front.sat;
        w_side_a.tir  = w_front.tir;
    end

    frs_delay #(
        .WIDTH ($bits(t_side_a)),
        .DEPTH (Q_LAT + S_LAT)
    ) u_side_a (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_data (w_side_a),
        .o_data (w_side_a_d)
    );

    // Fresnel products
    logic [46:0] r_p_ac;
    logic [46:0] r_p_bct;
    logic [46:0] r_p_bc;
    logic [46:0] r_p_act;
    t_side_a     r_p_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_ac   <= 47'(w_side_a_d.a) * 47'(w_side_a_d.ci);
            r_p_bct  <= 47'(w_side_a_d.b) * 47'(w_ct);
            r_p_bc   <= 47'(w_side_a_d.b) * 47'(w_side_a_d.ci);
            r_p_act  <= 47'(w_side_a_d.a) * 47'(w_ct);
            r_p_side <= w_side_a_d;
        end
    end

    // ratio operands
    logic signed [48:0] w_dp;
    logic signed [48:0] w_ds;
    logic        [47:0] w_mp;
    logic        [47:0] w_ms;
    logic        [47:0] w_enp;
    logic        [47:0] w_ens;
    logic        [64:0] r_r_nump;
    logic        [64:0] r_r_nums;
    logic        [47:0] r_r_denp;
    logic        [47:0] r_r_dens;
    t_side_b            n_side_b;
    t_side_b            r_r_side;

    assign w_dp  = $signed({2'b00, r_p_ac}) - $signed({2'b00, r_p_bct});
    assign w_ds  = $signed({2'b00, r_p_bc}) - $signed({2'b00, r_p_act});
    assign w_mp  = (w_dp < 49'sd0) ? 48'(-w_dp) : 48'(w_dp);
    assign w_ms  = (w_ds < 49'sd0) ? 48'(-w_ds) : 48'(w_ds);
    assign w_enp = 48'(r_p_ac) + 48'(r_p_bct);
    assign w_ens = 48'(r_p_bc) + 48'(r_p_act);

    always_comb begin
        n_side_b.zp   = (w_enp == '0);
        n_side_b.zs   = (w_ens == '0);
        n_side_b.tir  = r_p_side.tir;
        n_side_b.c16  = r_p_side.c16;
        n_side_b.refl = r_p_side.refl;
        n_side_b.sat  = r_p_side.sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r_nump <= (65'(w_mp) << 16) + 65'(w_enp >> 1);
            r_r_nums <= (65'(w_ms) << 16) + 65'(w_ens >> 1);
            r_r_denp <= w_enp;
            r_r_dens <= w_ens;
            r_r_side <= n_side_b;
        end
    end

    logic [16:0] w_rp_q;
    logic [16:0] w_rs_q;
    t_side_b     w_side_b_d;

    frs_div #(
        .NW (65),
        .DW (48),
        .QW (R_LAT)
    ) u_pdiv (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_r_nump),
        .i_den (r_r_denp),
        .o_quo (w_rp_q)
    );

    frs_div #(
        .NW (65),
        .DW (48),
        .QW (R_LAT)
    ) u_sdiv (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_r_nums),
        .i_den (r_r_dens),
        .o_quo (w_rs_q)
    );

    frs_delay #(
        .WIDTH ($bits(t_side_b)),
        .DEPTH (R_LAT)
    ) u_side_b (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_data (r_r_side),
        .o_data (w_side_b_d)
    );

    // squares, kr, weight operands
    logic [16:0] w_rp;
    logic [16:0] w_rs;
    logic [33:0] r_sq;
    t_side_b     r_sq_side;
    logic [16:0] r_kr;
    t_side_b     r_k_side;
    logic [33:0] w_wnum;
    logic [33:0] r_n_num;
    logic [32:0] r_n_den;
    t_side_c     n_side_c;
    t_side_c     r_n_side;

    assign w_rp = w_side_b_d.zp ? KR_ONE : w_rp_q;
    assign w_rs = w_side_b_d.zs ? KR_ONE : w_rs_q;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq      <= 34'(w_rp) * 34'(w_rp) + 34'(w_rs) * 34'(w_rs);
            r_sq_side <= w_side_b_d;
            r_kr      <= r_sq_side.tir ? KR_ONE : 17'((35'(r_sq) + 35'(KR_ONE)) >> 17);
            r_k_side  <= r_sq_side;
        end
    end

    assign w_wnum = (34'(r_kr) << 16) + 34'(r_k_side.c16 >> 1);

    always_comb begin
        n_side_c.kr   = r_kr;
        n_side_c.tir  = r_k_side.tir;
        n_side_c.ovf  = (57'(w_wnum) >= (57'(r_k_side.c16) << 24));
        n_side_c.refl = r_k_side.refl;
        n_side_c.sat  = r_k_side.sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n_num  <= w_wnum;
            r_n_den  <= r_k_side.c16;
            r_n_side <= n_side_c;
        end
    end

    logic [23:0] w_wq;
    t_side_c     w_side_c_d;

    frs_div #(
        .NW (34),
        .DW (33),
        .QW (W_LAT)
    ) u_wdiv (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_n_num),
        .i_den (r_n_den),
        .o_quo (w_wq)
    );

    frs_delay #(
        .WIDTH ($bits(t_side_c)),
        .DEPTH (W_LAT)
    ) u_side_c (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_data (r_n_side),
        .o_data (w_side_c_d)
    );

    // output word
    t_out_word n_out_word;
    t_out_word r_out_word;

    always_comb begin
        n_out_word.refl_x           = w_side_c_d.refl[0];
        n_out_word.refl_y           = w_side_c_d.refl[1];
        n_out_word.refl_z           = w_side_c_d.refl[2];
        n_out_word.reflectance      = w_side_c_d.kr;
        n_out_word.weight           = w_side_c_d.ovf ? WEIGHT_MAX : w_wq;
        n_out_word.total_internal   = w_side_c_d.tir;
        n_out_word.weight_saturated = w_side_c_d.sat | w_side_c_d.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_word = r_out_word;

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> (r_valid == $past(r_valid)))
        else $error("valid bits moved during a stall");

    a_kr_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.reflectance <= KR_ONE))
        else $error("reflectance above one");

    a_tir_kr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.total_internal) |-> (o_out_word.reflectance == KR_ONE))
        else $error("total internal reflection without kr of one");

endmodule

`default_nettype wire

### rtl/frs_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_delay
// Stallable delay line that keeps side data aligned with the long units.
// ----------------------------------------------------------------------------
module frs_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

`default_nettype wire

### rtl/frs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module frs_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [W-1:0]  w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_quo_in;
        logic [W-1:0]  w_sh;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = W'(i_num);
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_den_in = r_den[j-1];
            assign w_quo_in = r_quo[j-1];
        end

        assign w_sh = W'(w_den_in) << (QW - 1 - j);
        assign w_ge = (w_rem_in >= w_sh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? (w_rem_in - w_sh) : w_rem_in;
                r_den[j] <= w_den_in;
                r_quo[j] <= {w_quo_in[QW-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

### rtl/frs_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module frs_sqrt #(
    parameter int RW = 31
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_arg,
    output logic [RW-1:0]   o_root
);

    localparam int IW = 2 * RW;

    logic [IW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int B = RW - 1 - j;
        logic [IW-1:0] w_rem_in;
        logic [RW-1:0] w_root_in;
        logic [IW:0]   w_trial;
        logic [IW:0]   w_rem_x;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in  = i_arg;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
        end

        assign w_trial = ((IW+1)'(w_root_in) << (B + 1)) + ((IW+1)'(1) << (2 * B));
        assign w_rem_x = (IW+1)'(w_rem_in);
        assign w_ge    = (w_rem_x >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= w_ge ? IW'(w_rem_x - w_trial) : w_rem_in;
                r_root[j] <= w_root_in | (RW'(w_ge) << B);
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

`default_nettype wire

### rtl/frs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_front
// Dot products, mirror direction, incidence cosine and the sin^2 terms.
// ----------------------------------------------------------------------------
module frs_front
    import frs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_in_word    i_word,
    input  logic [15:0] i_index_inside,
    input  logic [15:0] i_index_outside,
    output t_front      o_front
);

    localparam int TWO_F = 2 * FRAC_BITS;
    localparam int C_RSH = (TWO_F > 30) ? TWO_F - 30 : 0;
    localparam int C_LSH = (TWO_F < 30) ? 30 - TWO_F : 0;
    localparam int C_SH  = TWO_F - 16;

    logic signed [15:0] w_n [3];
    logic signed [15:0] w_v [3];
    logic signed [15:0] w_d [3];

    assign w_n[0] = i_word.normal_x;
    assign w_n[1] = i_word.normal_y;
    assign w_n[2] = i_word.normal_z;
    assign w_v[0] = i_word.view_x;
    assign w_v[1] = i_word.view_y;
    assign w_v[2] = i_word.view_z;
    assign w_d[0] = i_word.ray_dir_x;
    assign w_d[1] = i_word.ray_dir_y;
    assign w_d[2] = i_word.ray_dir_z;

    // stage 1
    logic signed [31:0] r1_nv [3];
    logic signed [31:0] r1_nd [3];
    logic signed [15:0] r1_n  [3];
    logic signed [15:0] r1_v  [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_nv[k] <= w_n[k] * w_v[k];
                r1_nd[k] <= w_n[k] * w_d[k];
                r1_n[k]  <= w_n[k];
                r1_v[k]  <= w_v[k];
            end
        end
    end

    // stage 2
    logic signed [33:0] r2_ndv;
    logic signed [33:0] r2_ndd;
    logic signed [15:0] r2_n [3];
    logic signed [15:0] r2_v [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ndv <= 34'(r1_nv[0]) + 34'(r1_nv[1]) + 34'(r1_nv[2]);
            r2_ndd <= 34'(r1_nd[0]) + 34'(r1_nd[1]) + 34'(r1_nd[2]);
            r2_n   <= r1_n;
            r2_v   <= r1_v;
        end
    end

    // stage 3
    logic        [32:0] w_cmag;
    logic        [63:0] w_ci_w;
    logic        [30:0] w_ci;
    logic        [15:0] w_ii;
    logic        [15:0] w_io;
    logic               w_back;
    logic signed [50:0] r3_p [3];
    logic        [30:0] r3_ci;
    logic        [15:0] r3_a;
    logic        [15:0] r3_b;
    logic signed [15:0] r3_n [3];
    logic signed [15:0] r3_v [3];

    assign w_back = (r2_ndd > 34'sd0);
    assign w_cmag = w_back ? 33'(r2_ndd) : 33'(-r2_ndd);
    assign w_ci_w = (64'(w_cmag) >> C_RSH) << C_LSH;
    assign w_ci   = (w_ci_w > 64'(Q30_ONE)) ? Q30_ONE : w_ci_w[30:0];
    assign w_ii   = (i_index_inside  < INDEX_MIN) ? INDEX_MIN : i_index_inside;
    assign w_io   = (i_index_outside < INDEX_MIN) ? INDEX_MIN : i_index_outside;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_p[k] <= (51'(r2_ndv) * 51'(r2_n[k])) <<< 1;
            end
            r3_ci <= w_ci;
            r3_a  <= w_back ? w_io : w_ii;
            r3_b  <= w_back ? w_ii : w_io;
            r3_n  <= r2_n;
            r3_v  <= r2_v;
        end
    end

    // stage 4
    logic signed [63:0] w_y [3];
    logic signed [63:0] w_t [3];
    logic signed [15:0] w_r [3];
    logic        [2:0]  w_rsat;
    logic signed [15:0] r4_r [3];
    logic               r4_sat;
    logic        [61:0] r4_cc;
    logic        [31:0] r4_aa;
    logic        [31:0] r4_bb;
    logic signed [15:0] r4_n [3];
    logic        [30:0] r4_ci;
    logic        [15:0] r4_a;
    logic        [15:0] r4_b;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_y[k] = 64'(r3_p[k]) + (64'sd1 <<< (TWO_F - 1));
            w_t[k] = (w_y[k] >>> TWO_F) - 64'(r3_v[k]);
            if (w_t[k] > 64'sd32767) begin
                w_r[k]    = 16'sh7FFF;
                w_rsat[k] = 1'b1;
            end else if (w_t[k] < -64'sd32768) begin
                w_r[k]    = -16'sh8000;
                w_rsat[k] = 1'b1;
            end else begin
                w_r[k]    = 16'(w_t[k]);
                w_rsat[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_r   <= w_r;
            r4_sat <= |w_rsat;
            r4_cc  <= 62'(r3_ci) * 62'(r3_ci);
            r4_aa  <= 32'(r3_a) * 32'(r3_a);
            r4_bb  <= 32'(r3_b) * 32'(r3_b);
            r4_n   <= r3_n;
            r4_ci  <= r3_ci;
            r4_a   <= r3_a;
            r4_b   <= r3_b;
        end
    end

    // stage 5
    logic signed [31:0] r5_nr [3];
    logic        [30:0] r5_sin2;
    logic signed [15:0] r5_r [3];
    logic               r5_sat;
    logic        [31:0] r5_aa;
    logic        [31:0] r5_bb;
    logic        [30:0] r5_ci;
    logic        [15:0] r5_a;
    logic        [15:0] r5_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r5_nr[k] <= r4_n[k] * r4_r[k];
            end
            r5_sin2 <= Q30_ONE - 31'(r4_cc[61:30]);
            r5_r    <= r4_r;
            r5_sat  <= r4_sat;
            r5_aa   <= r4_aa;
            r5_bb   <= r4_bb;
            r5_ci   <= r4_ci;
            r5_a    <= r4_a;
            r5_b    <= r4_b;
        end
    end

    // stage 6
    logic signed [33:0] r6_ndr;
    logic        [62:0] r6_num;
    logic        [31:0] r6_den;
    logic signed [15:0] r6_r [3];
    logic               r6_sat;
    logic        [30:0] r6_ci;
    logic        [15:0] r6_a;
    logic        [15:0] r6_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_ndr <= 34'(r5_nr[0]) + 34'(r5_nr[1]) + 34'(r5_nr[2]);
            r6_num <= 63'(r5_sin2) * 63'(r5_bb);
            r6_den <= r5_aa;
            r6_r   <= r5_r;
            r6_sat <= r5_sat;
            r6_ci  <= r5_ci;
            r6_a   <= r5_a;
            r6_b   <= r5_b;
        end
    end

    // stage 7
    logic   [32:0] w_ndr_abs;
    logic   [33:0] w_c16_sum;
    t_front        n_front;
    t_front        r_front;

    assign w_ndr_abs = (r6_ndr < 34'sd0) ? 33'(-r6_ndr) : 33'(r6_ndr);
    assign w_c16_sum = 34'(w_ndr_abs) + (34'd1 << (C_SH - 1));

    always_comb begin
        n_front.num  = r6_num;
        n_front.den  = r6_den;
        n_front.tir  = (r6_num >= ((63'(r6_den) << 30) + 63'(r6_den)));
        n_front.ci   = r6_ci;
        n_front.a    = r6_a;
        n_front.b    = r6_b;
        n_front.c16  = 33'(w_c16_sum >> C_SH);
        for (int k = 0; k < 3; k++) begin
            n_front.refl[k] = r6_r[k];
        end
        n_front.sat  = r6_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

`default_nettype wire

### tb/fresnel_mirror_reflect_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fresnel_mirror_reflect_check
// Watches both word channels and the register port of the reflection block,
// computes the mirror direction, reflectance and weight of every accepted
// input word and compares them in order with the output words.
// ----------------------------------------------------------------------------
module fresnel_mirror_reflect_check
    import frs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_word             i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_word            i_out_word,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_out_count,
    output int                   o_tir_count,
    output int                   o_sat_count
);

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    logic [15:0] idx_in_q;
    logic [15:0] idx_out_q;
    t_out_word   expected_words[$];

    function automatic longint round_shift(longint x, int s);
        longint y;
        y = x + (longint'(1) << (s - 1));
        return y >>> s;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] term_q16(longint num, logic [63:0] den);
        logic [63:0] m;
        logic [63:0] r;
        m = (num < 0) ? -num : num;
        if (den == 0) return 64'd65536;
        r = ((m << 16) + den / 2) / den;
        return (r > 64'd65536) ? 64'd65536 : r;
    endfunction

    function automatic t_out_word reflect_word(t_in_word w, logic [15:0] ii_raw,
                                               logic [15:0] io_raw);
        longint n[3];
        longint v[3];
        longint d[3];
        longint ndv;
        longint ndd;
        longint ndr;
        longint t;
        longint cmag;
        longint ac;
        longint bct;
        longint bc;
        longint act;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ci;
        logic [63:0] sin2;
        logic [63:0] q;
        logic [63:0] kr;
        logic [63:0] ct;
        logic [63:0] rp;
        logic [63:0] rs;
        logic [63:0] cw;
        logic [63:0] c16;
        logic [63:0] wt;
        logic [63:0] ii;
        logic [63:0] io;
        logic sat;
        logic tir;
        t_out_word o;
        n = '{w.normal_x, w.normal_y, w.normal_z};
        v = '{w.view_x, w.view_y, w.view_z};
        d = '{w.ray_dir_x, w.ray_dir_y, w.ray_dir_z};
        ndv = 0;
        ndd = 0;
        ndr = 0;
        sat = 0;
        tir = 0;
        for (int k = 0; k < 3; k++) begin
            ndv += n[k] * v[k];
            ndd += n[k] * d[k];
        end
        for (int k = 0; k < 3; k++) begin
            t = round_shift(2 * ndv * n[k], 2 * FRAC_BITS) - v[k];
            if (t > 32767) begin
                t = 32767;
                sat = 1;
            end
            if (t < -32768) begin
                t = -32768;
                sat = 1;
            end
            o.refl_x = (k == 0) ? 16'(t) : o.refl_x;
            o.refl_y = (k == 1) ? 16'(t) : o.refl_y;
            o.refl_z = (k == 2) ? 16'(t) : o.refl_z;
            ndr += n[k] * t;
        end
        ii = (ii_raw < INDEX_MIN) ? INDEX_MIN : ii_raw;
        io = (io_raw < INDEX_MIN) ? INDEX_MIN : io_raw;
        if (ndd > 0) begin
            a = io;
            b = ii;
            cmag = ndd;
        end else begin
            a = ii;
            b = io;
            cmag = -ndd;
        end
        if (2 * FRAC_BITS >= 30) ci = 64'(cmag) >> (2 * FRAC_BITS - 30);
        else ci = 64'(cmag) << (30 - 2 * FRAC_BITS);
        if (ci > ONE_Q30) ci = ONE_Q30;
        sin2 = ONE_Q30 - ((ci * ci) >> 30);
        q = (sin2 * b * b) / (a * a);
        if (q > ONE_Q30) begin
            tir = 1;
            kr = 64'd65536;
        end else begin
            ct = int_sqrt((ONE_Q30 - q) << 30);
            ac = a * ci;
            bct = b * ct;
            bc = b * ci;
            act = a * ct;
            rp = term_q16(ac - bct, 64'(ac + bct));
            rs = term_q16(bc - act, 64'(bc + act));
            kr = (rp * rp + rs * rs + 64'd65536) >> 17;
        end
        cw = (ndr < 0) ? -ndr : ndr;
        c16 = (cw + (64'd1 << (2 * FRAC_BITS - 17))) >> (2 * FRAC_BITS - 16);
        if (c16 == 0) begin
            wt = WEIGHT_MAX;
            sat = 1;
        end else begin
            wt = ((kr << 16) + c16 / 2) / c16;
            if (wt > WEIGHT_MAX) begin
                wt = WEIGHT_MAX;
                sat = 1;
            end
        end
        o.reflectance = kr[16:0];
        o.weight = wt[23:0];
        o.total_internal = tir;
        o.weight_saturated = sat;
        return o;
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            idx_in_q <= INDEX_RESET;
            idx_out_q <= INDEX_RESET;
            expected_words.delete();
            o_fail_count <= 0;
            o_out_count <= 0;
            o_tir_count <= 0;
            o_sat_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_INDEX_INSIDE) idx_in_q <= i_cfg_data;
                if (i_cfg_idx == REG_INDEX_OUTSIDE) idx_out_q <= i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                o_out_count <= o_out_count + 1;
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output word %h", i_out_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_words.pop_front();
                    o_tir_count <= o_tir_count + e.total_internal;
                    o_sat_count <= o_sat_count + e.weight_saturated;
                    if (e !== i_out_word) begin
                        if (o_fail_count < 10)
                            $display("mismatch exp refl %0d %0d %0d kr %0d wt %0d tir %b sat %b",
                                e.refl_x, e.refl_y, e.refl_z, e.reflectance, e.weight,
                                e.total_internal, e.weight_saturated,
                                " / act refl %0d %0d %0d kr %0d wt %0d tir %b sat %b",
                                i_out_word.refl_x, i_out_word.refl_y, i_out_word.refl_z,
                                i_out_word.reflectance, i_out_word.weight,
                                i_out_word.total_internal, i_out_word.weight_saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(reflect_word(i_in_word, idx_in_q, idx_out_q));
        end
    end

endmodule

### tb/fresnel_mirror_reflect_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fresnel_mirror_reflect_test
// Drives directed and random rays through the reflection block under several
// index settings, with random gaps and a long output stall, and reports.
// ----------------------------------------------------------------------------
module fresnel_mirror_reflect_test;
    import frs_pkg::*;

    localparam int LATENCY     = 116;
    localparam int CYCLE_LIMIT = 600000;
    localparam int N_RANDOM    = 1500;
    localparam int N_PHASES    = 5;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_word             i_in_word;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_word            o_out_word;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0]          i_cfg_data;
    int                   fail_count;
    int                   pending;
    int                   out_count;
    int                   tir_count;
    int                   sat_count;
    int                   cycle_count;
    int                   stall_hold;
    logic                 sent_done;

    fresnel_mirror_reflect dut (.*);

    fresnel_mirror_reflect_check checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (o_out_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_out_count  (out_count),
        .o_tir_count  (tir_count),
        .o_sat_count  (sat_count)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout");
            $display("FAIL fresnel_mirror_reflect");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] unit_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh8000;
        if (r == 1) return 16'sh7fff;
        if (r < 4) return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // random components; in half of the words the normal is a rough unit vector along a random axis
    function automatic t_in_word rand_word();
        t_in_word w;
        int ax;
        w = '{default: '0};
        w.normal_x = unit_comp();
        w.normal_y = unit_comp();
        w.normal_z = unit_comp();
        w.view_x = unit_comp();
        w.view_y = unit_comp();
        w.view_z = unit_comp();
        w.ray_dir_x = unit_comp();
        w.ray_dir_y = unit_comp();
        w.ray_dir_z = unit_comp();
        if ($urandom_range(0, 1)) begin
            ax = $urandom_range(0, 2);
            w.normal_x = (ax == 0) ? 16'sd16384 : 16'($signed($urandom_range(0, 200)) - 100);
            w.normal_y = (ax == 1) ? 16'sd16384 : 16'($signed($urandom_range(0, 200)) - 100);
            w.normal_z = (ax == 2) ? -16'sd16384 : 16'($signed($urandom_range(0, 200)) - 100);
        end
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_indices(logic [15:0] in_index, logic [15:0] out_index);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_INDEX_INSIDE;
        i_cfg_data <= in_index;
        @(negedge i_clk);
        i_cfg_idx <= REG_INDEX_OUTSIDE;
        i_cfg_data <= out_index;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed_words();
        t_in_word w;
        w = '{default: '0};
        send_word(w);
        w = '{default: 16'sh7fff};
        send_word(w);
        w = '{default: 16'sh8000};
        send_word(w);
        w = '{default: 16'shffff};
        send_word(w);
        // head-on front hit
        w = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
              16'sd0, 16'sd0, -16'sd16384};
        send_word(w);
        // back side hit
        w.ray_dir_z = 16'sd16384;
        send_word(w);
        // grazing rays: total internal reflection when going out of dense medium
        w = '{16'sd0, 16'sd0, 16'sd16384, 16'sd16000, 16'sd0, 16'sd3000,
              16'sd16300, 16'sd0, 16'sd1000};
        send_word(w);
        w.ray_dir_z = -16'sd1000;
        send_word(w);
        // reflection perpendicular to normal, zero divisor
        w = '{16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0,
              16'sd0, 16'sd11585, -16'sd11585};
        send_word(w);
        // saturating reflection from non-unit normal
        w = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sd5, 16'sd5, 16'sd5};
        send_word(w);
        w = '{16'sh5555, -16'sh5555, 16'sh2aaa, 16'sh2aaa, 16'sh5555, -16'sh2aaa,
              16'sh5555, 16'sh2aaa, 16'sh5555};
        send_word(w);
    endtask

    // random output stalls, and one long stall so the pipeline fills and pushes back on input
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (stall_hold > 0) begin
                i_out_ready <= 1'b0;
                stall_hold <= stall_hold - 1;
                @(negedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat (gap_len() + 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
    end

    initial begin
        logic [15:0] ins[N_PHASES];
        logic [15:0] outs[N_PHASES];
        ins = '{16'd6144, 16'd1024, 16'd65535, 16'd100, 16'd4096};
        outs = '{16'd4096, 16'd65535, 16'd1024, 16'd5000, 16'd4096};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_INDEX_INSIDE;
        i_cfg_data = '0;
        cycle_count = 0;
        stall_hold = 0;
        sent_done = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        directed_words();
        for (int p = 0; p < N_PHASES; p++) begin
            set_indices(ins[p], outs[p]);
            if (p == 1) stall_hold <= 300;
            directed_words();
            for (int k = 0; k < N_RANDOM / N_PHASES; k++) send_word(rand_word());
        end
        i_in_valid <= 1'b0;
        sent_done = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("%0d words checked over %0d index settings, %0d total internal, %0d saturated",
                 out_count, N_PHASES + 1, tir_count, sat_count);
        if (fail_count == 0) begin
            $display("PASS fresnel_mirror_reflect");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAIL fresnel_mirror_reflect");
        end
        $finish;
    end

endmodule
